FILE: design/text_console_cursor_writer_defines.svh
// Assertion macros shared by the text console cursor writer RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside of reset.
`define TCCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tccw assertion failed");
// Checked on every rising edge, reset included.
`define TCCW_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tccw reset assertion failed");
`else
`define TCCW_ASSERT(lbl, prop)
`define TCCW_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: design/tccw_pkg.sv
// Types and constants of the text console cursor writer.
// No dependencies; imported by every module of the block but tccw_ram.
`default_nettype none

package tccw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_entry;
    logic [4:0]  pos_row;
    logic [6:0]  pos_col;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic write_cell;
    logic move;
    logic scroll_setup;
    logic clear_setup;
    logic sweep;
    logic read;
    logic capture;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       is_bs;
    logic       is_nl;
    logic       need_scroll;
    logic       sweep_last;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: design/tccw_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/tccw_ctrl.sv
// Controller state machine of the text console cursor writer.
// Depends on tccw_pkg and the assertion macro header.
`default_nettype none
`include "text_console_cursor_writer_defines.svh"

module tccw_ctrl
  import tccw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  typedef enum logic [10:0] {
    S_INIT     = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_DISPATCH = 11'b00000000100,
    S_WRITE    = 11'b00000001000,
    S_MOVE     = 11'b00000010000,
    S_ADDR     = 11'b00000100000,
    S_READ     = 11'b00001000000,
    S_RDATA    = 11'b00010000000,
    S_SWEEP    = 11'b00100000000,
    S_DONE     = 11'b01000000000,
    S_SPARE    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.kind == KIND_PUT) begin
          state_nxt = (sts.is_bs || sts.is_nl) ? S_MOVE : S_WRITE;
        end else if (sts.kind == KIND_READ) begin
          state_nxt = S_READ;
        end else if (sts.kind == KIND_CLEAR) begin
          cmd.clear_setup = 1'b1;
          state_nxt       = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write_cell = 1'b1;
        state_nxt      = sts.is_bs ? S_DONE : S_MOVE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        priority if (sts.is_bs) begin
          state_nxt = S_ADDR;
        end else if (sts.need_scroll) begin
          cmd.scroll_setup = 1'b1;
          state_nxt        = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ADDR: begin
        state_nxt = S_WRITE;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        cmd.capture = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TCCW_ASSERT(a_load_out_free, cmd.load_out |-> sts.out_free)
  `TCCW_ASSERT(a_accept_dispatch, (in_valid && in_ready) |=> (state_r == S_DISPATCH))
  `TCCW_ASSERT(a_one_write_source, !(cmd.sweep && cmd.write_cell))
  `TCCW_ASSERT_RST(a_reset_init, !rst_n |=> (state_r == S_INIT))

endmodule

`default_nettype wire

FILE: design/tccw_dpath.sv
// Datapath of the text console cursor writer: cursor, ring row offset,
// sweep counter, screen RAM and output register. Depends on tccw_pkg,
// tccw_ram and the assertion macro header.
`default_nettype none
`include "text_console_cursor_writer_defines.svh"

module tccw_dpath
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire ctl_cmd_t  cmd,
  output dp_sts_t        sts
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW:0]   ROWS_E   = (RW + 1)'(ROWS);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [AW-1:0] CELL_END = AW'(DEPTH - 1);

  logic [7:0]    attr_r;
  in_item_t      item_r;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] prow_r;
  logic [CW-1:0] pcol_r;
  logic [AW-1:0] swp_r, swp_end_r;
  logic [7:0]    swp_attr_r;
  logic [15:0]   entry_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic          is_read, is_bs, is_nl, wrap_row, rd_in_range;
  logic [RW-1:0] tgt_row;
  logic [CW-1:0] tgt_col;
  logic [RW:0]   row_sum;
  logic [AW-1:0] cell_addr, top_base, ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic          ram_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid) begin
      attr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  assign is_read  = (item_r.kind == KIND_READ);
  assign is_bs    = (item_r.kind == KIND_PUT) && (item_r.char_code == CH_BACKSPACE);
  assign is_nl    = (item_r.kind == KIND_PUT) && (item_r.char_code == CH_NEWLINE);
  assign wrap_row = is_nl || (cur_col_r == COL_LAST);
  assign rd_in_range = ({3'b000, item_r.read_row} < 8'(ROWS)) &&
                       ({1'b0, item_r.read_col} < 8'(COLUMNS));

  // Physical row of the addressed cell: logical row rotated by the ring offset.
  assign tgt_row = is_read ? RW'(item_r.read_row) : cur_row_r;
  assign tgt_col = is_read ? CW'(item_r.read_col) : cur_col_r;
  assign row_sum = {1'b0, tgt_row} + {1'b0, top_r};

  always_ff @(posedge clk) begin
    prow_r <= (row_sum >= ROWS_E) ? RW'(row_sum - ROWS_E) : RW'(row_sum);
    pcol_r <= tgt_col;
  end

  assign cell_addr = AW'(prow_r) * COLS_A + AW'(pcol_r);
  assign top_base  = AW'(top_r) * COLS_A;

  // Cursor movement and scrolling.
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    top_nxt     = top_r;
    if (cmd.clear_setup) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      top_nxt     = '0;
    end else if (cmd.move) begin
      if (is_bs) begin
        if (cur_col_r != '0) begin
          cur_col_nxt = cur_col_r - CW'(1);
        end else if (cur_row_r != '0) begin
          cur_row_nxt = cur_row_r - RW'(1);
          cur_col_nxt = COL_LAST;
        end
      end else if (wrap_row) begin
        cur_col_nxt = '0;
        if (cur_row_r != ROW_LAST) begin
          cur_row_nxt = cur_row_r + RW'(1);
        end
      end else begin
        cur_col_nxt = cur_col_r + CW'(1);
      end
      if (cmd.scroll_setup) begin
        top_nxt = (top_r == ROW_LAST) ? '0 : top_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      top_r     <= top_nxt;
    end
  end

  // Sweep counter for the reset pass, clear and the blanked bottom row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r      <= '0;
      swp_end_r  <= CELL_END;
      swp_attr_r <= ATTR_RESET;
    end else if (cmd.clear_setup) begin
      swp_r      <= '0;
      swp_end_r  <= CELL_END;
      swp_attr_r <= attr_r;
    end else if (cmd.scroll_setup) begin
      swp_r      <= top_base;
      swp_end_r  <= top_base + AW'(COLUMNS - 1);
      swp_attr_r <= attr_r;
    end else if (cmd.sweep) begin
      swp_r <= swp_r + AW'(1);
    end
  end

  assign ram_we    = cmd.sweep || cmd.write_cell;
  assign ram_addr  = cmd.sweep ? swp_r : cell_addr;
  assign ram_wdata = cmd.sweep ? {swp_attr_r, CH_SPACE}
                   : {attr_r, (is_bs ? CH_SPACE : item_r.char_code)};

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.read),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      entry_r <= rd_in_range ? ram_rdata : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.cell_entry <= is_read ? entry_r : 16'h0000;
      out_data_r.pos_row    <= 5'(cur_row_r);
      out_data_r.pos_col    <= 7'(cur_col_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.kind        = item_r.kind;
  assign sts.is_bs       = is_bs;
  assign sts.is_nl       = is_nl;
  assign sts.need_scroll = !is_bs && wrap_row && (cur_row_r == ROW_LAST);
  assign sts.sweep_last  = (swp_r == swp_end_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  `TCCW_ASSERT(a_cursor_range,
    ({1'b0, cur_row_r} < ROWS_E) && ({1'b0, cur_col_r} < (CW + 1)'(COLUMNS)))
  `TCCW_ASSERT(a_top_range, {1'b0, top_r} < ROWS_E)
  `TCCW_ASSERT(a_sweep_bound, cmd.sweep |-> (swp_r <= swp_end_r))

endmodule

`default_nettype wire

FILE: design/text_console_cursor_writer.sv
// Text console cursor writer: character-cell screen store plus cursor.
// One item at a time: the next is accepted once the result is registered. A scroll
// sweeps one row and a clear the whole store through the single-port screen RAM.
// Reset (rst_n low, synchronous) homes the cursor, then blanks all cells.
`default_nettype none

// The block keeps the screen in one single-port RAM of ROWS*COLUMNS 16-bit
// cells. Scrolling does not move data: the datapath keeps a ring offset that
// names the physical row holding logical row 0. Advancing that offset and
// blanking the old top row (which becomes the new bottom row) is the whole
// scroll, so it costs one RAM write per column.
//
// After reset the controller sweeps the entire store with space and the reset
// attribute, one cell per cycle. No input beat is taken during that pass;
// configuration beats are accepted at any time.
//
// Results sit in an output register, so the controller can return to idle and
// take the next input beat while a result beat is still waiting downstream.
// A result only blocks the controller if a new one is finished before the
// previous beat has been taken.

module text_console_cursor_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input beats: one item each.
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  // Result beats: one per input item.
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  // Attribute register write beats.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The controller sequences each item: decode, cell write, cursor move,
  // row or screen sweep, RAM read, and handing the result to the output.
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the item, cursor, ring offset, attribute, sweep
  // counter, the screen RAM and the output register.
  tccw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the text console cursor writer: put, read, clear and unused beats.
// Depends on tccw_pkg for the beat payload types, item kinds and character codes.
`default_nettype none

module tb_top;
  import tccw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  // The fourth kind code has no name in the package; the block must treat it as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles without any accepted beat before the run is declared hung. A clear or the
  // post-reset sweep writes all ROWS*COLS cells, so this sits well above that count.
  localparam int IDLE_LIMIT = 12000;
  localparam int PHASE_ITEMS = 80;
  localparam int PHASES = 5;
  // A scroll costs one RAM write per column, so this covers a result delayed by a scroll.
  localparam int DRAIN_CYCLES = COLS + 40;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  text_console_cursor_writer #(
    .COLUMNS(COLS),
    .ROWS(ROWS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the console: screen cells, cursor and attribute register. It is
  // advanced once per accepted input beat, in acceptance order, and produces
  // the result beat that the block owes for that item.
  // ---------------------------------------------------------------------------
  logic [15:0] screen_shadow [ROWS*COLS];
  int unsigned shadow_row;
  int unsigned shadow_col;
  logic [7:0]  shadow_attr;

  int unsigned scrolls = 0;
  int unsigned clears = 0;
  int unsigned reads_in_range = 0;
  int unsigned attr_writes = 0;

  function automatic logic [15:0] blank_cell();
    return {shadow_attr, CH_SPACE};
  endfunction

  task automatic blank_screen();
    for (int i = 0; i < ROWS*COLS; i++) screen_shadow[i] = blank_cell();
  endtask

  // Moves the cursor to column 0 of the next row. From the bottom row the whole
  // screen scrolls up one row and the freed bottom row is blanked.
  task automatic line_feed();
    shadow_col = 0;
    if (shadow_row + 1 < ROWS) begin
      shadow_row++;
    end else begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) screen_shadow[i] = screen_shadow[i+COLS];
      for (int c = 0; c < COLS; c++) screen_shadow[(ROWS-1)*COLS + c] = blank_cell();
      scrolls++;
    end
  endtask

  task automatic console_put(input logic [7:0] ch);
    if (ch == CH_BACKSPACE) begin
      // Step back, wrapping to the last column of the row above; the origin holds.
      if (shadow_col > 0) begin
        shadow_col--;
      end else if (shadow_row > 0) begin
        shadow_row--;
        shadow_col = COLS - 1;
      end
      screen_shadow[shadow_row*COLS + shadow_col] = blank_cell();
    end else if (ch == CH_NEWLINE) begin
      line_feed();
    end else begin
      screen_shadow[shadow_row*COLS + shadow_col] = {shadow_attr, ch};
      shadow_col++;
      if (shadow_col >= COLS) line_feed();
    end
  endtask

  task automatic console_step(input in_item_t it, output out_item_t res);
    logic [15:0] entry;
    entry = '0;
    case (it.kind)
      KIND_PUT: begin
        console_put(it.char_code);
      end
      KIND_READ: begin
        // Coordinates past the screen answer zero and touch nothing.
        if (it.read_row < ROWS && it.read_col < COLS) begin
          entry = screen_shadow[it.read_row*COLS + it.read_col];
          reads_in_range++;
        end
      end
      KIND_CLEAR: begin
        blank_screen();
        shadow_row = 0;
        shadow_col = 0;
        clears++;
      end
      default: begin
      end
    endcase
    res.cell_entry = entry;
    res.pos_row = shadow_row[4:0];
    res.pos_col = shadow_col[6:0];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus backlog and bookkeeping. Every input beat owes exactly one result
  // beat, so the block is idle once the matched results catch up with the
  // number of items ever queued.
  // ---------------------------------------------------------------------------
  in_item_t    item_backlog [$];
  out_item_t   expected_results [$];
  int unsigned n_queued = 0;
  int unsigned n_results = 0;
  int unsigned n_accepted = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  // Acceptance flags, set at the rising edge and read at the next falling edge.
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  task automatic queue_item(input logic [1:0] k, input logic [7:0] ch,
                            input logic [4:0] r, input logic [6:0] c);
    in_item_t it;
    it.kind = k;
    it.char_code = ch;
    it.read_row = r;
    it.read_col = c;
    item_backlog.push_back(it);
    n_queued++;
  endtask

  // The unused fields of each kind still carry random bits, so the block must
  // ignore them.
  task automatic queue_put(input logic [7:0] ch);
    queue_item(KIND_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic queue_read(input int r, input int c);
    queue_item(KIND_READ, 8'($urandom_range(0, 255)), r[4:0], c[6:0]);
  endtask

  task automatic wait_drained();
    while (n_results != n_queued) @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: beats leave the backlog in bursts of random length separated
  // by random gaps. A beat that is offered stays put until it is taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        in_data <= item_backlog.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          // About a third of bursts run straight into the next one.
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: alternates ready runs and stall runs. Ready runs are
  // sometimes long enough to let several results through back to back.
  // ---------------------------------------------------------------------------
  logic        rx_open = 1'b0;
  int unsigned rx_run = 0;

  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_open = ~rx_open;
      if (rx_open) begin
        rx_run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end else begin
        rx_run = $urandom_range(0, 6);
      end
    end else begin
      rx_run--;
    end
    out_ready <= rx_open;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge. A result beat is
  // checked against the oldest expectation before the input beat of the same
  // edge is predicted, since that result belongs to an earlier item.
  // ---------------------------------------------------------------------------
  out_item_t want;
  out_item_t got;

  always @(posedge clk) begin
    in_taken = 1'b0;
    cfg_taken = 1'b0;
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      cfg_taken = cfg_valid && cfg_ready;
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result beat: cell_entry %h row %0d col %0d",
                     got.cell_entry, got.pos_row, got.pos_col);
          end
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (got.cell_entry !== want.cell_entry || got.pos_row !== want.pos_row ||
              got.pos_col !== want.pos_col) begin
            errors++;
            if (errors <= 10) begin
              $display(
                "result %0d: entry exp %h got %h, row exp %0d got %0d, col exp %0d got %0d",
                n_results, want.cell_entry, got.cell_entry, want.pos_row,
                got.pos_row, want.pos_col, got.pos_col);
            end
          end
        end
      end
      if (in_taken) begin
        console_step(in_data, want);
        expected_results.push_back(want);
        n_accepted++;
      end
      if (cfg_taken) begin
        shadow_attr = cfg_data;
        attr_writes++;
      end
      if (in_taken || cfg_taken || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                   idle_cycles, expected_results.size());
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned phase_count;
    int unsigned base;
    int unsigned pick;
    int unsigned n;
    int idx;
    logic [7:0] phase_attr;

    // The shadow starts from the reset picture: blank screen, attribute 15,
    // cursor at the origin.
    shadow_attr = ATTR_RESET;
    blank_screen();
    shadow_row = 0;
    shadow_col = 0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset attribute. The block sweeps its store
    // first, so these beats wait until that pass is over.
    queue_put(8'h41);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(8'h80);
    queue_read(0, 0);
    queue_read(0, 3);
    queue_put(CH_BACKSPACE);           // back from column 4 to column 3
    queue_read(0, 3);
    queue_put(CH_NEWLINE);
    queue_put(CH_BACKSPACE);           // from column 0 up to the end of row 0
    queue_read(0, COLS - 1);
    queue_read(ROWS - 1, COLS - 1);
    queue_read(ROWS, 0);               // row just past the screen
    queue_read(0, COLS);               // column just past the screen
    queue_read(31, 127);
    queue_item(KIND_UNUSED, 8'hFF, 5'd31, 7'd127);
    queue_item(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
    queue_put(CH_BACKSPACE);           // at the origin the cursor stays
    queue_read(0, 0);
    queue_put(CH_SPACE);
    queue_put(8'h7F);
    queue_read(0, 1);

    for (int p = 0; p < PHASES; p++) begin
      // The attribute only changes while nothing is in flight.
      wait_drained();
      repeat (4) @(negedge clk);
      case (p)
        0: phase_attr = 8'h00;
        1: phase_attr = 8'hFF;
        default: phase_attr = 8'($urandom_range(0, 255));
      endcase
      write_attr(phase_attr);

      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        base = n_queued;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // A run of text, mostly printable.
          n = $urandom_range(1, 30);
          repeat (n) begin
            if ($urandom_range(0, 4) != 0) queue_put(8'($urandom_range(32, 126)));
            else queue_put(8'($urandom_range(0, 255)));
          end
        end else if (pick < 44) begin
          // Newline runs walk the cursor down and, from the bottom row, scroll.
          n = $urandom_range(1, 30);
          repeat (n) queue_put(CH_NEWLINE);
        end else if (pick < 51) begin
          n = $urandom_range(1, 50);
          repeat (n) queue_put(CH_BACKSPACE);
        end else if (pick < 57) begin
          // A line long enough to wrap past the last column.
          n = COLS + $urandom_range(0, 3);
          repeat (n) queue_put(8'($urandom_range(32, 126)));
        end else if (pick < 70) begin
          // Reads biased toward the top and bottom rows and the left edge,
          // with some over the full field range.
          n = $urandom_range(1, 4);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
              queue_read($urandom_range(0, 31), $urandom_range(0, 127));
            end else begin
              queue_read(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(ROWS - 3, ROWS - 1),
                         ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, COLS - 1));
            end
          end
        end else if (pick < 84) begin
          // Read back the cell at the cursor and those just behind it once everything has landed.
          wait_drained();
          n = $urandom_range(1, 6);
          for (int j = 0; j <= n; j++) begin
            idx = shadow_row*COLS + shadow_col - j;
            if (idx >= 0) queue_read(idx / COLS, idx % COLS);
          end
        end else if (pick < 88) begin
          n = $urandom_range(1, 3);
          repeat (n) queue_item(KIND_UNUSED, 8'($urandom_range(0, 255)),
                                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        end else if (pick < 90) begin
          queue_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
        end else begin
          // Noise: every field at random, the clear kind left out to keep it rare.
          n = $urandom_range(1, 8);
          repeat (n) begin
            queue_item(($urandom_range(0, 2) == 0) ? KIND_UNUSED
                                                   : (($urandom_range(0, 1) == 0) ? KIND_PUT
                                                                                  : KIND_READ),
                       8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                       7'($urandom_range(0, 127)));
          end
        end
        phase_count += n_queued - base;
      end
    end

    // Let every result arrive, then watch a while longer for stray beats.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d items under %0d attribute settings: %0d in-range reads,",
             n_accepted, attr_writes + 1, reads_in_range);
    $display("%0d scrolls, %0d clears, %0d failures", scrolls, clears, errors);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
